// ===== hw/rtl/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

    // operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int unsigned COUNT_OUT_W = 11;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]       min_key;
        logic                     is_empty;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic [1:0]               status;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_min_heap_queue_core.sv =====
// result timing: an insert climbs one level per S_UP_CHK/S_UP_CMP pass; a remove loads the
//   last entry in S_DN_LD and sinks one level per S_DN_CHK/S_DN_RDR/S_DN_CMP pass, or stops
//   when the heap ends empty; full-insert or empty-remove go straight to S_DONE; longer while
//   a result waits
// throughput: one item at a time, the next is accepted only once the result is registered
// reset: synchronous active-low, empties the heap (count to zero); key memory is not cleared
`default_nettype none

module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = AW + 2;
    localparam int unsigned EW = CW + COUNT_OUT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CHK = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_DN_LD  = 3'd3;
    localparam logic [2:0] S_DN_CHK = 3'd4;
    localparam logic [2:0] S_DN_RDR = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_left, n_left;
    logic               r_has_r, n_has_r;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_root;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;

    logic               w_wr_en, w_rd_en;
    logic [AW-1:0]      w_wr_addr, w_rd_addr;
    logic signed [31:0] w_wr_data;

    logic [AW-1:0]      w_parent;
    logic [XW-1:0]      w_left_idx, w_right_idx, w_count_x;
    logic               w_lsel, w_rsel;
    logic signed [31:0] w_cand;
    logic               w_out_free, w_load;
    logic [EW-1:0]      w_cnt_wide;

    assign w_parent    = AW'((r_pos - AW'(1)) >> 1);
    assign w_left_idx  = {1'b0, r_pos, 1'b1};
    assign w_right_idx = w_left_idx + XW'(1);
    assign w_count_x   = XW'(r_count);

    // hole-based sift: the moving key stays in r_key and is written once at the end
    assign w_lsel = r_left < r_key;
    assign w_cand = w_lsel ? r_left : r_key;
    assign w_rsel = r_has_r && (r_rdata < w_cand);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = (r_state == S_DONE) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_left    = r_left;
        n_has_r   = r_has_r;
        n_status  = r_status;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_key;
        w_rd_en   = 1'b0;
        w_rd_addr = w_parent;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_key    = i_in_item.key_in;
                    if (i_in_item.cmd == CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            n_state = S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // fetch the last entry, it becomes the moving key
                            n_count   = r_count - CW'(1);
                            n_pos     = '0;
                            w_rd_en   = 1'b1;
                            w_rd_addr = AW'(r_count - CW'(1));
                            n_state   = S_DN_LD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_wr_en = 1'b1;
                if (r_key < r_rdata) begin
                    w_wr_data = r_rdata;
                    n_pos     = w_parent;
                    n_state   = S_UP_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LD: begin
                n_key   = r_rdata;
                n_state = (r_count == '0) ? S_DONE : S_DN_CHK;
            end
            S_DN_CHK: begin
                if (w_left_idx >= w_count_x) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_left_idx[AW-1:0];
                    n_state   = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_left  = r_rdata;
                n_has_r = w_right_idx < w_count_x;
                if (w_right_idx < w_count_x) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_right_idx[AW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_wr_en = 1'b1;
                // left child wins ties; equal keys never move
                if (w_rsel) begin
                    w_wr_data = r_rdata;
                    n_pos     = w_right_idx[AW-1:0];
                    n_state   = S_DN_CHK;
                end else if (w_lsel) begin
                    w_wr_data = r_left;
                    n_pos     = w_left_idx[AW-1:0];
                    n_state   = S_DN_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // mirror of the root entry for the min_key field
    always_ff @(posedge i_clk) begin
        if (w_wr_en && (w_wr_addr == '0)) begin
            r_root <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cnt_wide = EW'(r_count);

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_left  <= n_left;
        r_has_r <= n_has_r;
        r_status <= n_status;
        if (w_load) begin
            r_out.min_key     <= (r_count != '0) ? r_root : 32'sd0;
            r_out.is_empty    <= (r_count == '0);
            r_out.entry_count <= w_cnt_wide[COUNT_OUT_W-1:0];
            r_out.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (CW'(w_wr_addr) < r_count))
        else $error("write beyond stored entries");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (CW'(w_rd_addr) < r_count))
        else $error("read of an unwritten entry");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

endmodule

`default_nettype wire
